FILE: rtl/core/gradient_palette_entry_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gradient palette entry core
// Implication checks, same cycle and next cycle, gated by reset.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_PALETTE_ENTRY_CORE_MACROS_SVH
`define GRADIENT_PALETTE_ENTRY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define GPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define GPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/gpe_pkg.sv
// ---------------------------------------------------------------------------
// gpe_pkg
// Shared constants for the gradient palette entry core.
// ---------------------------------------------------------------------------
package gpe_pkg;

    localparam int STOP_REGS      = 6;
    localparam int COLOR_W        = 32;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 4;
    localparam int IDX_W          = 12;
    localparam int SIZE_W         = 13;
    localparam int COUNT_W        = 3;
    localparam int ADDR_W         = 3;
    localparam int SEG_W          = 3;

    localparam int MAX_STOPS_DEF  = 6;
    localparam int MAX_SIZE_DEF   = 4096;
    localparam int POS_FRAC_DEF   = 16;

    // register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_STOP_COUNT = 3'd6;
    localparam logic [ADDR_W-1:0] REG_GRAD_SIZE  = 3'd7;

    // default gradient, positions in Q.16
    localparam int RST_POS16 [STOP_REGS] = '{0, 10486, 27525, 42107, 43090, 65536};
    localparam logic [COLOR_W-1:0] RST_COLOR [STOP_REGS] = '{
        32'hFF640700, 32'hFFCB6B20, 32'hFFFFFFED,
        32'hFF00AAFF, 32'hFF000200, 32'hFF000000
    };
    localparam logic [COUNT_W-1:0] RST_COUNT = 3'd6;
    localparam logic [SIZE_W-1:0]  RST_SIZE  = 13'd256;

endpackage

FILE: rtl/core/gpe_div_pipe.sv
// ---------------------------------------------------------------------------
// gpe_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num >> QUO_W < den, so the quotient fits QUO_W bits.
// ---------------------------------------------------------------------------
module gpe_div_pipe #(
    parameter int NUM_W  = 28,
    parameter int DEN_W  = 13,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num_i,
    input  logic [DEN_W-1:0]  den_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo_o,
    output logic [SIDE_W-1:0] side_o
);

    logic              valid_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg   [QUO_W];
    logic [NUM_W-1:0]  num_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic              valid_in;
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  num_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic              take;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (i == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = DEN_W'(num_i >> QUO_W);
            assign num_in   = num_i;
            assign den_in   = den_i;
            assign quo_in   = '0;
            assign side_in  = side_i;
        end else begin : g_rest
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign num_in   = num_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        always_comb begin
            trial    = {rem_in, num_in[QUO_W-1-i]};
            take     = trial >= {1'b0, den_in};
            rem_next = take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            quo_next = quo_in;
            quo_next[QUO_W-1-i] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                num_reg[i]  <= num_in;
                den_reg[i]  <= den_in;
                quo_reg[i]  <= quo_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo_o     = quo_reg[QUO_W-1];
    assign side_o    = side_reg[QUO_W-1];

endmodule

FILE: rtl/core/gpe_blend.sv
// ---------------------------------------------------------------------------
// gpe_blend
// Output stage: per-channel a + (b - a) * c, floored, registered; zero when bad_i is set.
// ---------------------------------------------------------------------------
module gpe_blend #(
    parameter int POS_FRAC_BITS = gpe_pkg::POS_FRAC_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         bad_i,
    input  logic [POS_FRAC_BITS:0]       c_i,
    input  logic [gpe_pkg::COLOR_W-1:0]  color_a,
    input  logic [gpe_pkg::COLOR_W-1:0]  color_b,
    output logic                         out_valid,
    output logic [gpe_pkg::COLOR_W-1:0]  color_o,
    output logic                         bad_o
);

    localparam int F     = POS_FRAC_BITS;
    localparam int CW    = gpe_pkg::CHAN_W;
    localparam int ACC_W = F + CW + 3;

    logic                        valid_reg;
    logic [gpe_pkg::COLOR_W-1:0] color_reg;
    logic                        bad_reg;
    logic [gpe_pkg::COLOR_W-1:0] color_next;

    always_comb begin
        logic [CW-1:0]          a;
        logic [CW-1:0]          b;
        logic signed [CW:0]     diff;
        logic signed [F+1:0]    cs;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] base;
        logic signed [ACC_W-1:0] acc;
        color_next = '0;
        for (int ch = 0; ch < gpe_pkg::NUM_CHAN; ch++) begin
            a    = color_a[ch*CW +: CW];
            b    = color_b[ch*CW +: CW];
            diff = $signed({1'b0, b}) - $signed({1'b0, a});
            cs   = $signed({1'b0, c_i});
            prod = ACC_W'(diff) * ACC_W'(cs);
            base = $signed({{(ACC_W-CW-F){1'b0}}, a, {F{1'b0}}});
            acc  = base + prod;
            if (!acc[ACC_W-1] && !bad_i) begin
                color_next[ch*CW +: CW] = acc[F +: CW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            color_reg <= color_next;
            bad_reg   <= bad_i;
        end
    end

    assign out_valid = valid_reg;
    assign color_o   = color_reg;
    assign bad_o     = bad_reg;

endmodule

FILE: rtl/core/gradient_palette_entry_core.sv
// ---------------------------------------------------------------------------
// gradient_palette_entry_core
// Palette entry to ARGB colour over a gradient of up to six stops.
// ---------------------------------------------------------------------------
// Takes one index per cycle while the output is not stalled and returns its
// colour through an input register, two bit-per-stage dividers (position =
// index/(size-1) and fraction within the segment), a segment register and
// the blend register. The whole pipeline holds while a result waits on m_tready.
// Indices at or past gradient_size, and malformed stop tables, give bad in
// tuser and a zero colour. Write configuration only while the core is empty.
module gradient_palette_entry_core #(
    parameter int MAX_STOPS     = gpe_pkg::MAX_STOPS_DEF,
    parameter int MAX_SIZE      = gpe_pkg::MAX_SIZE_DEF,
    parameter int POS_FRAC_BITS = gpe_pkg::POS_FRAC_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gpe_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [POS_FRAC_BITS+32:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // index[11:0], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // blue, green, red, alpha
    output logic [0:0]                      m_tuser   // bad
);

    localparam int F      = POS_FRAC_BITS;
    localparam int POS_W  = F + 1;
    localparam int STOP_W = F + 33;
    localparam int NS     = gpe_pkg::STOP_REGS;
    localparam int SEG_W  = gpe_pkg::SEG_W;
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << F;

    function automatic logic [POS_W-1:0] rst_pos(input int k);
        if (F >= 16) begin
            return POS_W'(gpe_pkg::RST_POS16[k] << (F - 16));
        end else begin
            return POS_W'(gpe_pkg::RST_POS16[k] >> (16 - F));
        end
    endfunction

    // configuration
    logic [STOP_W-1:0]             stop_reg  [NS];
    logic [gpe_pkg::COUNT_W-1:0]   count_reg;
    logic [gpe_pkg::SIZE_W-1:0]    size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                stop_reg[k] <= {rst_pos(k), gpe_pkg::RST_COLOR[k]};
            end
            count_reg <= gpe_pkg::RST_COUNT;
            size_reg  <= gpe_pkg::RST_SIZE;
        end else if (cfg_wr_en) begin
            if (32'(cfg_addr) < NS) begin
                stop_reg[cfg_addr] <= cfg_wdata;
            end else if (cfg_addr == gpe_pkg::REG_STOP_COUNT) begin
                count_reg <= cfg_wdata[gpe_pkg::COUNT_W-1:0];
            end else if (cfg_addr == gpe_pkg::REG_GRAD_SIZE) begin
                size_reg <= cfg_wdata[gpe_pkg::SIZE_W-1:0];
            end
        end
    end

    logic [POS_W-1:0]            stop_pos [NS];
    logic [gpe_pkg::COLOR_W-1:0] stop_col [NS];
    for (genvar k = 0; k < NS; k++) begin : g_split
        assign stop_pos[k] = stop_reg[k][STOP_W-1:gpe_pkg::COLOR_W];
        assign stop_col[k] = stop_reg[k][gpe_pkg::COLOR_W-1:0];
    end

    // table and size checks depend on configuration only
    logic cfg_bad;
    always_comb begin
        cfg_bad = (size_reg < 2) || (32'(size_reg) > MAX_SIZE) || (count_reg < 2) ||
                  (32'(count_reg) > MAX_STOPS) || (32'(count_reg) > NS);
        if (stop_pos[0] != '0) begin
            cfg_bad = 1'b1;
        end
        for (int k = 1; k < NS; k++) begin
            if (32'(count_reg) == k + 1 && stop_pos[k] != ONE_POS) begin
                cfg_bad = 1'b1;
            end
            if (32'(count_reg) > k && stop_pos[k] <= stop_pos[k-1]) begin
                cfg_bad = 1'b1;
            end
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input stage
    logic                      in_valid_reg;
    logic [gpe_pkg::IDX_W-1:0] idx_reg;
    logic                      in_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg    <= s_tdata[gpe_pkg::IDX_W-1:0];
            in_bad_reg <= cfg_bad ||
                          ({1'b0, s_tdata[gpe_pkg::IDX_W-1:0]} >= size_reg);
        end
    end

    // position = index * 2^F / (size - 1)
    logic             pos_valid;
    logic [POS_W-1:0] pos;
    logic [0:0]       pos_bad;

    gpe_div_pipe #(
        .NUM_W  (gpe_pkg::IDX_W + F),
        .DEN_W  (gpe_pkg::SIZE_W),
        .QUO_W  (POS_W),
        .SIDE_W (1)
    ) u_pos_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .num_i     ({idx_reg, {F{1'b0}}}),
        .den_i     (size_reg - 1'b1),
        .side_i    (in_bad_reg),
        .out_valid (pos_valid),
        .quo_o     (pos),
        .side_o    (pos_bad)
    );

    // segment select: first used stop at or above pos
    logic [SEG_W-1:0] seg_next;
    always_comb begin
        seg_next = SEG_W'(1);
        for (int k = NS - 1; k >= 1; k--) begin
            if (32'(count_reg) > k && stop_pos[k] >= pos) begin
                seg_next = SEG_W'(k);
            end
        end
    end

    logic             seg_valid_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [POS_W-1:0] diff_reg;
    logic [POS_W-1:0] span_reg;
    logic             seg_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_valid_reg <= 1'b0;
        end else if (en) begin
            seg_valid_reg <= pos_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg_reg     <= seg_next;
            diff_reg    <= pos - stop_pos[seg_next - 1'b1];
            span_reg    <= stop_pos[seg_next] - stop_pos[seg_next - 1'b1];
            seg_bad_reg <= pos_bad[0];
        end
    end

    // fraction within the segment
    logic             frac_valid;
    logic [POS_W-1:0] frac;
    logic [SEG_W:0]   frac_side;

    gpe_div_pipe #(
        .NUM_W  (POS_W + F),
        .DEN_W  (POS_W),
        .QUO_W  (POS_W),
        .SIDE_W (SEG_W + 1)
    ) u_frac_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (seg_valid_reg),
        .num_i     ({diff_reg, {F{1'b0}}}),
        .den_i     (span_reg),
        .side_i    ({seg_bad_reg, seg_reg}),
        .out_valid (frac_valid),
        .quo_o     (frac),
        .side_o    (frac_side)
    );

    logic [SEG_W-1:0] frac_seg;
    logic [POS_W-1:0] frac_clip;
    assign frac_seg  = frac_side[SEG_W-1:0];
    assign frac_clip = (frac > ONE_POS) ? ONE_POS : frac;

    logic [gpe_pkg::COLOR_W-1:0] color_out;
    logic                        bad_out;

    gpe_blend #(
        .POS_FRAC_BITS (F)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (frac_valid),
        .bad_i     (frac_side[SEG_W]),
        .c_i       (frac_clip),
        .color_a   (stop_col[frac_seg - 1'b1]),
        .color_b   (stop_col[frac_seg]),
        .out_valid (m_tvalid),
        .color_o   (color_out),
        .bad_o     (bad_out)
    );

    // alpha in the lowest byte
    assign m_tdata = {color_out[7:0], color_out[15:8], color_out[23:16], color_out[31:24]};
    assign m_tuser = bad_out;

`include "gradient_palette_entry_core_macros.svh"

    `GPE_ASSERT_IMPL(a_bad_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `GPE_ASSERT_IMPL(a_count_bad, aclk, aresetn, m_tvalid && (count_reg < 2), m_tuser[0])
    `GPE_ASSERT_IMPL(a_stall_intake, aclk, aresetn, m_tvalid && !m_tready, !s_tready)

endmodule
